@@ hdl/amgs_pkg.sv @@
// Shared types and codes for the adjacency matrix graph store.
// Used by the sequencer, the row update logic and the top level.
package amgs_pkg;

  // Request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_INS_VTX  = 3'd0,
    REQ_DEL_VTX  = 3'd1,
    REQ_INS_EDGE = 3'd2,
    REQ_DEL_EDGE = 3'd3,
    REQ_LIST     = 3'd4
  } req_e;

  // Cell codes held in the matrix
  localparam logic [1:0] CELL_ABSENT = 2'd0;
  localparam logic [1:0] CELL_NOEDGE = 2'd1;
  localparam logic [1:0] CELL_EDGE   = 2'd2;

  // Kind of row rewrite applied during a walk
  typedef enum logic {
    UPD_VERTEX = 1'b0,
    UPD_EDGE   = 1'b1
  } upd_kind_e;

  // One result beat handed from the sequencer to the output register
  typedef struct packed {
    logic [3:0] neighbor;
    logic       neighbor_valid;
    logic       last;
    logic       ignored;
    logic       is_empty;
    logic       is_full;
    logic [4:0] vertex_count;
  } result_t;

endpackage

@@ hdl/adjacency_matrix_graph_store.sv @@
// Adjacency matrix graph store, top level: sequencer, matrix memory, output beat register.
// After reset the matrix is cleared one row a cycle; no request is taken meanwhile.
// Vertex insert/delete walks the rows below the span, then the vertex row if past it (span is
// the count after an insert, before a delete); an edge walks one or two rows; a list reads its row.
// The pace is one matrix row read and written back per cycle through the single memory port pair.
// Depends on amgs_pkg, amgs_matrix, amgs_ctrl.
module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic [3:0] vertex_a_i,
  input  logic [3:0] vertex_b_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] neighbor_o,
  output logic       neighbor_valid_o,
  output logic       last_o,
  output logic       ignored_o,
  output logic       is_empty_o,
  output logic       is_full_o,
  output logic [4:0] vertex_count_o
);

  localparam int RW = $clog2(MAX_VERTICES);

  logic                      rd_en, wr_en;
  logic [RW-1:0]             rd_addr, wr_addr;
  logic [2*MAX_VERTICES-1:0] rd_data, wr_data;
  logic                      res_load, slot_free;
  result_t                   res, res_q;
  logic                      out_valid_q;

  amgs_matrix #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_matrix (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  amgs_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .vertex_a_i (vertex_a_i),
    .vertex_b_i (vertex_b_i),
    .slot_free_i(slot_free),
    .res_load_o (res_load),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Output beat register: free when empty or being taken
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && slot_free) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neighbor_o       = res_q.neighbor;
  assign neighbor_valid_o = res_q.neighbor_valid;
  assign last_o           = res_q.last;
  assign ignored_o        = res_q.ignored;
  assign is_empty_o       = res_q.is_empty;
  assign is_full_o        = res_q.is_full;
  assign vertex_count_o   = res_q.vertex_count;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> slot_free)
    else $error("result beat loaded while output register is held");

  a_found_not_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && neighbor_valid_o |-> !ignored_o)
    else $error("neighbor beat flagged as ignored");

  a_ignored_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ignored_o |-> last_o)
    else $error("ignored request produced more than one beat");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !neighbor_valid_o |-> (neighbor_o == 4'd0) && last_o)
    else $error("beat without neighbor is not a clean final beat");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && in_ready_o |-> 1'b0)
    else $error("matrix written while a new request can be taken");
`endif

endmodule

@@ hdl/amgs_matrix.sv @@
// Cell matrix storage: one row of two-bit cells per entry.
// One write and one registered read per cycle; no package dependency.
module amgs_matrix #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     rd_addr_i,
  output logic [2*MAX_VERTICES-1:0]           rd_data_o,
  input  logic                                wr_en_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     wr_addr_i,
  input  logic [2*MAX_VERTICES-1:0]           wr_data_i
);

  logic [2*MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [2*MAX_VERTICES-1:0] rd_data_q;

  // Write one row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one row, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/amgs_row_upd.sv @@
// Row rewrite for vertex and edge requests: one matrix row in, one out.
// Depends on amgs_pkg for cell and update kind codes.
module amgs_row_upd
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  upd_kind_e                           kind_i,
  input  logic [1:0]                          val_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     row_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     a_row_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     b_row_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]   span_i,
  input  logic [2*MAX_VERTICES-1:0]           old_i,
  output logic [2*MAX_VERTICES-1:0]           new_o
);

  localparam int RW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Set the cells of the vertex row and column below the span,
  // or the one symmetric cell of an edge in this row
  always_comb begin
    new_o = old_i;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      case (kind_i)
        UPD_VERTEX: begin
          if ((row_i == a_row_i && CW'(j) < span_i) ||
              (RW'(j) == a_row_i && CW'(row_i) < span_i)) begin
            new_o[2*j +: 2] = val_i;
          end
        end
        UPD_EDGE: begin
          if ((row_i == a_row_i && RW'(j) == b_row_i) ||
              (row_i == b_row_i && RW'(j) == a_row_i)) begin
            new_o[2*j +: 2] = val_i;
          end
        end
        default: new_o[2*j +: 2] = old_i[2*j +: 2];
      endcase
    end
  end

endmodule

@@ hdl/amgs_ctrl.sv @@
// Request sequencer: clears the matrix after reset, walks rows with
// read-modify-write, scans a row for neighbors and builds result beats.
// Depends on amgs_pkg, amgs_row_upd.
module amgs_ctrl
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          req_type_i,
  input  logic [3:0]                          vertex_a_i,
  input  logic [3:0]                          vertex_b_i,
  input  logic                                slot_free_i,
  output logic                                res_load_o,
  output result_t                             res_o,
  output logic                                rd_en_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr_o,
  input  logic [2*MAX_VERTICES-1:0]           rd_data_i,
  output logic                                wr_en_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     wr_addr_o,
  output logic [2*MAX_VERTICES-1:0]           wr_data_o
);

  localparam int RW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = (CW > 4) ? CW : 4;
  localparam int LW  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int LIW = (LW > 1) ? $clog2(LW) : 1;
  localparam logic [AW-1:0] MaxExt  = AW'(MAX_VERTICES);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_VERTICES);
  localparam logic [RW-1:0] LastRow = RW'(MAX_VERTICES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_LIST_WAIT,
    ST_LIST_EMIT,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  upd_kind_e       kind_q, kind_d;
  logic [1:0]      val_q, val_d;
  logic [RW-1:0]   a_row_q, a_row_d;
  logic [RW-1:0]   b_row_q, b_row_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   span_q, span_d;
  logic [RW-1:0]   ptr_q, ptr_d;
  logic            phase_q, phase_d;
  logic            ign_q, ign_d;
  logic            wb_q, wb_d;
  logic [RW-1:0]   wb_row_q, wb_row_d;
  logic [LW-1:0]   mask_q, mask_d;

  logic [AW-1:0]   a_ext, b_ext, cnt_ext;
  logic [2*MAX_VERTICES-1:0] row_new;
  logic [LIW-1:0]  low_idx;
  logic [LW-1:0]   mask_rest;
  logic            is_empty, is_full;
  logic [4:0]      count_out;

  assign a_ext   = AW'(vertex_a_i);
  assign b_ext   = AW'(vertex_b_i);
  assign cnt_ext = AW'(cnt_q);

  assign is_empty  = (cnt_q == '0);
  assign is_full   = (cnt_q == MaxCnt);
  assign count_out = 5'(cnt_q);

  assign in_ready_o = (state_q == ST_IDLE);

  // Rewrite the row read in the previous cycle
  amgs_row_upd #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_row_upd (
    .kind_i (kind_q),
    .val_i  (val_q),
    .row_i  (wb_row_q),
    .a_row_i(a_row_q),
    .b_row_i(b_row_q),
    .span_i (span_q),
    .old_i  (rd_data_i),
    .new_o  (row_new)
  );

  // Find the lowest pending neighbor
  always_comb begin
    low_idx = '0;
    for (int j = LW - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        low_idx = LIW'(j);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - LW'(1));

  // Write port: clearing pass or writeback of a walked row
  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en_o   = 1'b1;
      wr_addr_o = ptr_q;
      wr_data_o = '0;
    end else begin
      wr_en_o   = wb_q;
      wr_addr_o = wb_row_q;
      wr_data_o = row_new;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    val_d     = val_q;
    a_row_d   = a_row_q;
    b_row_d   = b_row_q;
    cnt_d     = cnt_q;
    span_d    = span_q;
    ptr_d     = ptr_q;
    phase_d   = phase_q;
    ign_d     = ign_q;
    wb_d      = 1'b0;
    wb_row_d  = wb_row_q;
    mask_d    = mask_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q;
    res_load_o = 1'b0;
    res_o      = '{neighbor: '0, neighbor_valid: 1'b0, last: 1'b1,
                   ignored: ign_q, is_empty: is_empty, is_full: is_full,
                   vertex_count: count_out};

    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == LastRow) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + RW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          a_row_d = RW'(vertex_a_i);
          b_row_d = RW'(vertex_b_i);
          ign_d   = 1'b0;
          ptr_d   = '0;
          phase_d = 1'b0;
          state_d = ST_EMIT;
          unique case (req_e'(req_type_i)) inside
            REQ_INS_VTX: begin
              if (cnt_q == MaxCnt || a_ext >= MaxExt) begin
                ign_d = 1'b1;
              end else begin
                cnt_d   = cnt_q + CW'(1);
                span_d  = cnt_q + CW'(1);
                kind_d  = UPD_VERTEX;
                val_d   = CELL_NOEDGE;
                state_d = ST_WALK;
              end
            end
            REQ_DEL_VTX: begin
              if (cnt_q == '0 || a_ext >= MaxExt) begin
                ign_d = 1'b1;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                span_d  = cnt_q;
                kind_d  = UPD_VERTEX;
                val_d   = CELL_ABSENT;
                state_d = ST_WALK;
              end
            end
            REQ_INS_EDGE, REQ_DEL_EDGE: begin
              if (a_ext > cnt_ext || b_ext > cnt_ext ||
                  a_ext >= MaxExt || b_ext >= MaxExt) begin
                ign_d = 1'b1;
              end else begin
                kind_d  = UPD_EDGE;
                val_d   = (req_e'(req_type_i) == REQ_INS_EDGE) ? CELL_EDGE : CELL_NOEDGE;
                ptr_d   = RW'(vertex_a_i);
                state_d = ST_WALK;
              end
            end
            REQ_LIST: begin
              if (a_ext >= MaxExt) begin
                ign_d = 1'b1;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = RW'(vertex_a_i);
                state_d   = ST_LIST_WAIT;
              end
            end
            default: ign_d = 1'b1;
          endcase
        end
      end

      ST_WALK: begin
        // Read one row; it is written back next cycle
        rd_en_o   = 1'b1;
        rd_addr_o = ptr_q;
        wb_d      = 1'b1;
        wb_row_d  = ptr_q;
        if (kind_q == UPD_EDGE) begin
          if (!phase_q && b_row_q != a_row_q) begin
            ptr_d   = b_row_q;
            phase_d = 1'b1;
          end else begin
            state_d = ST_DRAIN;
          end
        end else if (phase_q) begin
          state_d = ST_DRAIN;
        end else if (CW'(ptr_q) == span_q - CW'(1)) begin
          if (CW'(a_row_q) >= span_q) begin
            ptr_d   = a_row_q;
            phase_d = 1'b1;
          end else begin
            state_d = ST_DRAIN;
          end
        end else begin
          ptr_d = ptr_q + RW'(1);
        end
      end

      ST_DRAIN: begin
        state_d = ST_EMIT;
      end

      ST_LIST_WAIT: begin
        for (int j = 0; j < LW; j++) begin
          mask_d[j] = (rd_data_i[2*j +: 2] == CELL_EDGE);
        end
        state_d = ST_LIST_EMIT;
      end

      ST_LIST_EMIT: begin
        if (slot_free_i) begin
          res_load_o = 1'b1;
          if (mask_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            res_o.neighbor       = 4'(low_idx);
            res_o.neighbor_valid = 1'b1;
            res_o.last           = (mask_rest == '0);
            mask_d               = mask_rest;
            if (mask_rest == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_EMIT: begin
        if (slot_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      ptr_q    <= '0;
      phase_q  <= 1'b0;
      ign_q    <= 1'b0;
      wb_q     <= 1'b0;
      kind_q   <= UPD_VERTEX;
      val_q    <= CELL_ABSENT;
      a_row_q  <= '0;
      b_row_q  <= '0;
      span_q   <= '0;
      wb_row_q <= '0;
      mask_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      phase_q  <= phase_d;
      ign_q    <= ign_d;
      wb_q     <= wb_d;
      kind_q   <= kind_d;
      val_q    <= val_d;
      a_row_q  <= a_row_d;
      b_row_q  <= b_row_d;
      span_q   <= span_d;
      wb_row_q <= wb_row_d;
      mask_q   <= mask_d;
    end
  end

endmodule

@@ tb/graph_store_checker.sv @@
// Scoreboard for the adjacency matrix graph store: watches both channels, keeps its own
// copy of the matrix and vertex count, and checks every result beat in order.
// Depends on amgs_pkg for the request codes, cell codes and result_t.
module graph_store_checker
  import amgs_pkg::*;
#(
  parameter int VERTEX_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] req_type_i,
  input  logic [3:0] vertex_a_i,
  input  logic [3:0] vertex_b_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [3:0] neighbor_i,
  input  logic       neighbor_valid_i,
  input  logic       last_i,
  input  logic       ignored_i,
  input  logic       is_empty_i,
  input  logic       is_full_i,
  input  logic [4:0] vertex_count_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         beats_checked_o,
  output int         neighbor_beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  // Only the first sixteen columns can be reported as neighbors
  localparam int LIST_LIMIT   = 16;

  logic [1:0] cells [VERTEX_SLOTS][VERTEX_SLOTS];
  int         live_count;
  result_t    awaited_beats [$];
  result_t    want_beat;
  result_t    got_beat;
  int         mismatches;
  int         beats_checked;
  int         neighbor_beats;

  // Build one result beat from the count as it stands after the request
  function automatic result_t graph_beat(logic [3:0] nb, logic nb_ok, logic fin, logic rej);
    result_t r;
    r.neighbor       = nb;
    r.neighbor_valid = nb_ok;
    r.last           = fin;
    r.ignored        = rej;
    r.is_empty       = (live_count == 0);
    r.is_full        = (live_count == VERTEX_SLOTS);
    r.vertex_count   = 5'(live_count);
    return r;
  endfunction

  // Apply one request to the shadow graph and queue the beats it should produce
  task automatic apply_graph_request(input logic [2:0] req, input logic [3:0] a,
                                     input logic [3:0] b);
    logic                    rej;
    logic [VERTEX_SLOTS-1:0] hits;
    int                      total;
    int                      seen;
    int                      i;
    rej   = 1'b0;
    hits  = '0;
    total = 0;
    seen  = 0;
    case (req) inside
      REQ_INS_VTX: begin
        if (live_count >= VERTEX_SLOTS || a >= VERTEX_SLOTS) begin
          rej = 1'b1;
        end else begin
          live_count++;
          for (i = 0; i < live_count; i++) begin
            cells[a][i] = CELL_NOEDGE;
            cells[i][a] = CELL_NOEDGE;
          end
        end
      end
      REQ_DEL_VTX: begin
        if (live_count == 0 || a >= VERTEX_SLOTS) begin
          rej = 1'b1;
        end else begin
          for (i = 0; i < live_count; i++) begin
            cells[a][i] = CELL_ABSENT;
            cells[i][a] = CELL_ABSENT;
          end
          live_count--;
        end
      end
      REQ_INS_EDGE, REQ_DEL_EDGE: begin
        // an end equal to the count still passes the range check
        if (a > live_count || b > live_count || a >= VERTEX_SLOTS || b >= VERTEX_SLOTS) begin
          rej = 1'b1;
        end else begin
          cells[a][b] = (req == REQ_INS_EDGE) ? CELL_EDGE : CELL_NOEDGE;
          cells[b][a] = (req == REQ_INS_EDGE) ? CELL_EDGE : CELL_NOEDGE;
        end
      end
      REQ_LIST: begin
        if (a >= VERTEX_SLOTS) begin
          rej = 1'b1;
        end else begin
          for (i = 0; i < VERTEX_SLOTS && i < LIST_LIMIT; i++) begin
            hits[i] = (cells[a][i] == CELL_EDGE);
            if (hits[i]) total++;
          end
        end
      end
      default: rej = 1'b1;
    endcase

    // Listing emits one beat per neighbor in ascending order; all else emits one beat
    if (req == REQ_LIST && total > 0) begin
      for (i = 0; i < VERTEX_SLOTS && i < LIST_LIMIT; i++) begin
        if (hits[i]) begin
          seen++;
          awaited_beats.push_back(graph_beat(4'(i), 1'b1, seen == total, 1'b0));
        end
      end
    end else begin
      awaited_beats.push_back(graph_beat(4'd0, 1'b0, 1'b1, rej));
    end
  endtask

  // Predict on each input beat, compare on each output beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < VERTEX_SLOTS; r++) begin
        for (int c = 0; c < VERTEX_SLOTS; c++) begin
          cells[r][c] = CELL_ABSENT;
        end
      end
      live_count     = 0;
      mismatches     = 0;
      beats_checked  = 0;
      neighbor_beats = 0;
      awaited_beats.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        apply_graph_request(req_type_i, vertex_a_i, vertex_b_i);
      end
      if (out_valid_i && out_ready_i) begin
        got_beat.neighbor       = neighbor_i;
        got_beat.neighbor_valid = neighbor_valid_i;
        got_beat.last           = last_i;
        got_beat.ignored        = ignored_i;
        got_beat.is_empty       = is_empty_i;
        got_beat.is_full        = is_full_i;
        got_beat.vertex_count   = vertex_count_i;
        if (awaited_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result beat with nothing awaited: nb=%0d nv=%0b last=%0b",
                     $time, neighbor_i, neighbor_valid_i, last_i);
          end
        end else begin
          want_beat = awaited_beats.pop_front();
          beats_checked++;
          if (want_beat.neighbor_valid) neighbor_beats++;
          if (want_beat.neighbor !== got_beat.neighbor ||
              want_beat.neighbor_valid !== got_beat.neighbor_valid ||
              want_beat.last !== got_beat.last ||
              want_beat.ignored !== got_beat.ignored ||
              want_beat.is_empty !== got_beat.is_empty ||
              want_beat.is_full !== got_beat.is_full ||
              want_beat.vertex_count !== got_beat.vertex_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: beat %0d expected nb=%0d nv=%0b last=%0b ",
                       $time, beats_checked, want_beat.neighbor, want_beat.neighbor_valid,
                       want_beat.last,
                       "ign=%0b emp=%0b full=%0b cnt=%0d",
                       want_beat.ignored, want_beat.is_empty,
                       want_beat.is_full, want_beat.vertex_count);
              $display("%0t: beat %0d actual   nb=%0d nv=%0b last=%0b ",
                       $time, beats_checked, got_beat.neighbor, got_beat.neighbor_valid,
                       got_beat.last,
                       "ign=%0b emp=%0b full=%0b cnt=%0d",
                       got_beat.ignored, got_beat.is_empty,
                       got_beat.is_full, got_beat.vertex_count);
            end
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= awaited_beats.size();
    beats_checked_o  <= beats_checked;
    neighbor_beats_o <= neighbor_beats;
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the graph store testbench: clock, reset, request stimulus, result back-pressure
// and the verdict. Depends on amgs_pkg, adjacency_matrix_graph_store and graph_store_checker.
module tb_top
  import amgs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS          = 16;
  localparam int          ITEM_TARGET    = 360;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam logic [2:0]  REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  REQ_RSVD_LAST  = 3'd7;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [2:0] req_type       = 3'd0;
  logic [3:0] vertex_a       = 4'd0;
  logic [3:0] vertex_b       = 4'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [3:0] neighbor;
  logic       neighbor_valid;
  logic       last;
  logic       ignored;
  logic       is_empty;
  logic       is_full;
  logic [4:0] vertex_count;

  int mismatch_count;
  int pending_beats;
  int beats_checked;
  int neighbor_beats;

  int requests_sent = 0;
  int noise_sent    = 0;
  int live_est      = 0;
  int next_gap      = 0;
  int idle_cycles   = 0;
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;
  bit rx_hold       = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adjacency_matrix_graph_store #(.MAX_VERTICES(SLOTS)) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .vertex_a_i      (vertex_a),
    .vertex_b_i      (vertex_b),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .neighbor_o      (neighbor),
    .neighbor_valid_o(neighbor_valid),
    .last_o          (last),
    .ignored_o       (ignored),
    .is_empty_o      (is_empty),
    .is_full_o       (is_full),
    .vertex_count_o  (vertex_count)
  );

  graph_store_checker #(.VERTEX_SLOTS(SLOTS)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .req_type_i      (req_type),
    .vertex_a_i      (vertex_a),
    .vertex_b_i      (vertex_b),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .neighbor_i      (neighbor),
    .neighbor_valid_i(neighbor_valid),
    .last_i          (last),
    .ignored_i       (ignored),
    .is_empty_i      (is_empty),
    .is_full_i       (is_full),
    .vertex_count_i  (vertex_count),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_beats),
    .beats_checked_o (beats_checked),
    .neighbor_beats_o(neighbor_beats)
  );

  // Offer one request beat after the gap drawn for it; keep valid high across back-to-back beats
  task automatic send_request(input logic [2:0] req, input logic [3:0] a, input logic [3:0] b);
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      repeat (next_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    // track the vertex count to steer edge ends into range and to pick inserts or deletes
    if (req == REQ_INS_VTX && live_est < SLOTS) live_est++;
    if (req == REQ_DEL_VTX && live_est > 0) live_est--;
    next_gap = tx_steady ? 0 : $urandom_range(0, 9);
  endtask

  // Edge end that passes the range check
  function automatic logic [3:0] pick_end();
    return 4'($urandom_range(0, (live_est > SLOTS - 1) ? SLOTS - 1 : live_est));
  endfunction

  // Receiver: stall a random number of cycles before each result beat, or hold off on request
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold) begin
        stall   = HOLD_CYCLES;
        rx_hold = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int         pick;
    int         burst;
    logic [3:0] v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty graph: list, delete, self edge at the count boundary, list, out-of-range edge, reserved codes
    send_request(REQ_LIST, 4'd0, 4'd0);
    send_request(REQ_DEL_VTX, 4'd3, 4'd0);
    send_request(REQ_INS_EDGE, 4'd0, 4'd0);
    send_request(REQ_LIST, 4'd0, 4'd0);
    send_request(REQ_INS_EDGE, 4'd1, 4'd0);
    send_request(REQ_RSVD_FIRST, 4'd15, 4'd15);
    send_request(REQ_RSVD_LAST, 4'd0, 4'd15);
    // Fill to full, then insert once more
    for (int i = 0; i < SLOTS; i++) begin
      send_request(REQ_INS_VTX, 4'(i), 4'd0);
    end
    send_request(REQ_INS_VTX, 4'd9, 4'd0);
    // Edges at the top index, list, remove, list again, delete at the top
    send_request(REQ_INS_EDGE, 4'd15, 4'd15);
    send_request(REQ_INS_EDGE, 4'd0, 4'd15);
    send_request(REQ_LIST, 4'd15, 4'd0);
    send_request(REQ_DEL_EDGE, 4'd15, 4'd0);
    send_request(REQ_LIST, 4'd0, 4'd0);
    send_request(REQ_DEL_VTX, 4'd15, 4'd0);

    // Long receiver hold-off while requests keep coming
    rx_hold = 1'b1;
    repeat (10) send_request(REQ_LIST, 4'($urandom_range(0, 15)), 4'd0);

    // Random phase: mostly well-formed sequences, some noise
    while (requests_sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      pick      = $urandom_range(0, 99);
      if (pick < 30) begin
        // add a burst of edges around one vertex, then list it
        v     = pick_end();
        burst = $urandom_range(1, 6);
        repeat (burst) send_request(REQ_INS_EDGE, v, pick_end());
        send_request(REQ_LIST, v, 4'($urandom_range(0, 15)));
      end else if (pick < 45) begin
        send_request((live_est == SLOTS) ? REQ_DEL_VTX : REQ_INS_VTX,
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 58) begin
        send_request((live_est == 0) ? REQ_INS_VTX : REQ_DEL_VTX,
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 72) begin
        v = pick_end();
        send_request(REQ_DEL_EDGE, v, pick_end());
        send_request(REQ_LIST, v, 4'd0);
      end else if (pick < 82) begin
        send_request(REQ_LIST, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 86) begin
        while (live_est < SLOTS) send_request(REQ_INS_VTX, 4'($urandom_range(0, 15)), 4'd0);
        send_request(REQ_INS_VTX, 4'($urandom_range(0, 15)), 4'd0);
      end else if (pick < 89) begin
        while (live_est > 0) send_request(REQ_DEL_VTX, 4'($urandom_range(0, 15)), 4'd0);
        send_request(REQ_DEL_VTX, 4'($urandom_range(0, 15)), 4'd0);
      end else begin
        // raw noise: any code, any ends
        send_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
        noise_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results; the pending count seen here is registered in the checker
    do @(posedge clk); while (pending_beats != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests sent (%0d raw noise), %0d result beats checked",
             requests_sent, noise_sent, beats_checked);
    $display("Summary: %0d beats carried neighbors; empty, full and long-stall phases driven",
             neighbor_beats);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
